[sv/fwrl_pkg.sv]
// ----------------------------------------------------------------------------
// fwrl_pkg
// Shared codes and the request token that walks the cell chain.
// ----------------------------------------------------------------------------
package fwrl_pkg;

    localparam logic [2:0] REQ_SET   = 3'd0;
    localparam logic [2:0] REQ_CHECK = 3'd1;
    localparam logic [2:0] REQ_QUERY = 3'd2;
    localparam logic [2:0] REQ_RESET = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    localparam int FLOW_KEY_W = 16;
    localparam int LIMIT_W    = 16;
    localparam int TIME_W     = 32;
    localparam int REM_W      = 17;
    localparam int WIN_W      = 16;

    localparam logic [LIMIT_W-1:0] COUNT_MAX = '1;

    // one request as it passes from cell to cell
    typedef struct packed {
        logic                    valid;
        logic [2:0]              req;
        logic                    kind;
        logic [FLOW_KEY_W-1:0]   key;
        logic [LIMIT_W-1:0]      lim;
        logic [TIME_W-1:0]       now;
        logic                    succ;
        logic                    found;
        logic signed [REM_W-1:0] rem;
    } token_t;

endpackage

[sv/fwrl_if.sv]
// ----------------------------------------------------------------------------
// fwrl channel interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface fwrl_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic        flow_kind;
    logic [15:0] flow_key;
    logic [15:0] new_limit;
    logic [31:0] now_time;
    modport source (output valid, req_type, flow_kind, flow_key, new_limit, now_time,
                    input ready);
    modport sink   (input valid, req_type, flow_kind, flow_key, new_limit, now_time,
                    output ready);
endinterface

interface fwrl_rsp_if;
    logic               valid;
    logic               ready;
    logic               success;
    logic               found;
    logic signed [16:0] remaining;
    modport source (output valid, success, found, remaining, input ready);
    modport sink   (input valid, success, found, remaining, output ready);
endinterface

interface fwrl_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[sv/fwrl_cell.sv]
// ----------------------------------------------------------------------------
// fwrl_cell
// One table entry. Acts on the passing token and hands it to the next cell.
// ----------------------------------------------------------------------------
module fwrl_cell #(
    parameter int IDX    = 0,
    parameter int KW     = 16,
    parameter int USED_W = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [USED_W-1:0]                 used,
    input  logic [fwrl_pkg::WIN_W-1:0]        window_length,
    input  fwrl_pkg::token_t                  tok_in,
    output fwrl_pkg::token_t                  tok_out
);

    localparam logic [USED_W-1:0] MY_IDX = USED_W'(IDX);

    logic [KW-1:0]                    key_reg;
    logic                             kind_reg;
    logic [fwrl_pkg::LIMIT_W-1:0]     limit_reg;
    logic [fwrl_pkg::LIMIT_W-1:0]     count_reg;
    logic [fwrl_pkg::TIME_W-1:0]      start_reg;
    fwrl_pkg::token_t                 tok_reg;
    fwrl_pkg::token_t                 tok_next;

    logic                             live;
    logic                             match;
    logic                             expired;
    logic [fwrl_pkg::LIMIT_W-1:0]     cnt_eff;
    logic                             deny;

    // match and window status
    always_comb
    begin
        live    = MY_IDX < used;
        match   = tok_in.valid && live && (kind_reg == tok_in.kind)
                  && (key_reg == tok_in.key[KW-1:0]);
        expired = (tok_in.now - start_reg) >= {16'd0, window_length};
        cnt_eff = expired ? '0 : count_reg;
        deny    = (limit_reg != '0) && (cnt_eff >= limit_reg);
    end

    // token update
    always_comb
    begin
        tok_next = tok_in;
        if (match)
        begin
            case (tok_in.req)
                fwrl_pkg::REQ_SET:
                begin
                    tok_next.succ  = 1'b1;
                    tok_next.found = 1'b1;
                end
                fwrl_pkg::REQ_CHECK:
                begin
                    tok_next.found = 1'b1;
                    tok_next.succ  = !deny;
                end
                fwrl_pkg::REQ_QUERY:
                begin
                    tok_next.found = 1'b1;
                    tok_next.rem   = expired ? $signed({1'b0, limit_reg})
                                   : $signed({1'b0, limit_reg}) - $signed({1'b0, count_reg});
                end
                default:
                begin
                end
            endcase
        end
        else if (tok_in.valid && tok_in.req == fwrl_pkg::REQ_SET && !tok_in.found
                 && MY_IDX == used)
        begin
            tok_next.succ = 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (match)
        begin
            case (tok_in.req)
                fwrl_pkg::REQ_SET:
                begin
                    limit_reg <= tok_in.lim;
                end
                fwrl_pkg::REQ_CHECK:
                begin
                    if (expired)
                    begin
                        start_reg <= tok_in.now;
                    end
                    if (!deny && cnt_eff != fwrl_pkg::COUNT_MAX)
                    begin
                        count_reg <= cnt_eff + 1'b1;
                    end
                    else
                    begin
                        count_reg <= cnt_eff;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (tok_in.valid && tok_in.req == fwrl_pkg::REQ_SET && !tok_in.found
                 && MY_IDX == used)
        begin
            key_reg   <= tok_in.key[KW-1:0];
            kind_reg  <= tok_in.kind;
            limit_reg <= tok_in.lim;
            count_reg <= '0;
            start_reg <= tok_in.now;
        end
        if (tok_in.valid && live && tok_in.req == fwrl_pkg::REQ_RESET)
        begin
            count_reg <= '0;
            start_reg <= tok_in.now;
        end
    end

    // hand token on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[sv/fixed_window_rate_limit_table.sv]
// ----------------------------------------------------------------------------
// fixed_window_rate_limit_table
// Per-flow fixed-window rate limiter table built as a chain of entry cells.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  req      in   req_type, flow_kind, flow_key, new_limit, now_time
//  rsp      out  success, found, remaining
//  cfg      in   data (window_length)
//
//  A request word is registered at launch, walks the chain one cell per cycle,
//  then passes through a pending register into the output register. One request is in flight at
//  a time; the next is taken once the previous result sits in the output
//  register. Reset clears the fill count; window_length returns to 60.
// ----------------------------------------------------------------------------
module fixed_window_rate_limit_table #(
    parameter int SLOTS    = 128,
    parameter int KEY_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    fwrl_req_if.sink  req,
    fwrl_rsp_if.source rsp,
    fwrl_cfg_if.sink  cfg
);

    localparam int KW     = (KEY_BITS < fwrl_pkg::FLOW_KEY_W) ? KEY_BITS : fwrl_pkg::FLOW_KEY_W;
    localparam int USED_W = $clog2(SLOTS + 1);
    localparam logic [USED_W-1:0] FULL = USED_W'(SLOTS);

    fwrl_pkg::token_t              chain [SLOTS+1];
    fwrl_pkg::token_t              launch_reg, launch_next;
    fwrl_pkg::token_t              pend_reg;
    logic                          pend_valid_reg;
    logic                          busy_reg;
    logic [USED_W-1:0]             used_reg;
    logic [fwrl_pkg::WIN_W-1:0]    window_reg;
    logic                          out_valid_reg;
    logic                          out_succ_reg;
    logic                          out_found_reg;
    logic signed [fwrl_pkg::REM_W-1:0] out_rem_reg;
    logic                          out_free;
    logic                          accept;

    assign req.ready = !busy_reg;
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && !busy_reg;
    assign out_free  = !out_valid_reg || rsp.ready;

    // build the launch word with default results per request
    always_comb
    begin
        launch_next       = '0;
        launch_next.valid = accept;
        launch_next.req   = req.req_type;
        launch_next.kind  = req.flow_kind;
        launch_next.key   = fwrl_pkg::FLOW_KEY_W'(req.flow_key[KW-1:0]);
        launch_next.lim   = req.new_limit;
        launch_next.now   = req.now_time;
        case (req.req_type)
            fwrl_pkg::REQ_CHECK, fwrl_pkg::REQ_RESET, fwrl_pkg::REQ_CLEAR:
            begin
                launch_next.succ = 1'b1;
            end
            fwrl_pkg::REQ_QUERY:
            begin
                launch_next.succ = 1'b1;
                launch_next.rem  = '1;
            end
            default:
            begin
            end
        endcase
    end

    assign chain[0] = launch_reg;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            fwrl_cell #(
                .IDX    (g),
                .KW     (KW),
                .USED_W (USED_W)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .used          (used_reg),
                .window_length (window_reg),
                .tok_in        (chain[g]),
                .tok_out       (chain[g+1])
            );
        end
    endgenerate

    // control: launch, fill count, pending result, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg     <= '0;
            busy_reg       <= 1'b0;
            used_reg       <= '0;
            window_reg     <= fwrl_pkg::WIN_W'(60);
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            launch_reg <= launch_next;
            if (cfg.valid)
            begin
                window_reg <= cfg.data;
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            if (chain[SLOTS].valid)
            begin
                pend_valid_reg <= 1'b1;
                if (chain[SLOTS].req == fwrl_pkg::REQ_CLEAR)
                begin
                    used_reg <= '0;
                end
                else if (chain[SLOTS].req == fwrl_pkg::REQ_SET && !chain[SLOTS].found
                         && used_reg != FULL)
                begin
                    used_reg <= used_reg + 1'b1;
                end
            end
            if (out_free)
            begin
                out_valid_reg <= pend_valid_reg;
                if (pend_valid_reg)
                begin
                    pend_valid_reg <= 1'b0;
                    busy_reg       <= 1'b0;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (chain[SLOTS].valid)
        begin
            pend_reg <= chain[SLOTS];
        end
        if (out_free && pend_valid_reg)
        begin
            out_succ_reg  <= pend_reg.succ;
            out_found_reg <= pend_reg.found;
            out_rem_reg   <= pend_reg.rem;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.success   = out_succ_reg;
    assign rsp.found     = out_found_reg;
    assign rsp.remaining = out_rem_reg;

endmodule
